@@ rtl/mic_sample_conditioner_vad_macros.svh @@
// Assertion macros shared by the conditioner RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef MIC_SAMPLE_CONDITIONER_VAD_MACROS_SVH
`define MIC_SAMPLE_CONDITIONER_VAD_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define MSCV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define MSCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mscvad_pkg.sv @@
// Types and constants of the microphone sample conditioner.
// No dependencies; imported by the controller, datapath and top level.
package mscvad_pkg;

  // Fixed field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned FILT_W  = 40;
  localparam int unsigned ACC_W   = 58;
  localparam int unsigned MUL_W   = 38;
  localparam int unsigned ENER_W  = 43;
  localparam int unsigned THR_W   = 42;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned FLEN_W  = 13;
  localparam int unsigned PCM_W   = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned APB_AW  = 6;
  localparam int unsigned APB_DW  = 64;

  // Register reset values
  localparam logic [15:0]       RST_FILTER_COEFF = 16'd63570;
  localparam logic [15:0]       RST_GAIN         = 16'd256;
  localparam logic [15:0]       RST_WARMUP       = 16'd1600;
  localparam logic [FLEN_W-1:0] RST_FRAME_LEN    = 13'd320;
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = 42'd80000000;
  localparam logic [CNT_W-1:0]  RST_GRACE        = 24'd16000;
  localparam logic [CNT_W-1:0]  RST_HANGOVER     = 24'd16000;
  localparam logic [CNT_W-1:0]  RST_CAPACITY     = 24'd160000;

  typedef enum logic [2:0] {
    REG_FILTER_COEFF,
    REG_GAIN,
    REG_WARMUP,
    REG_FRAME_LEN,
    REG_THRESHOLD,
    REG_GRACE,
    REG_HANGOVER,
    REG_CAPACITY
  } reg_idx_e;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_FULL    = 2'd1,
    REASON_SILENCE = 2'd2
  } stop_reason_e;

  typedef enum logic [0:0] {
    CMD_WORD  = 1'b0,
    CMD_START = 1'b1
  } command_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FACC,
    ST_FILT,
    ST_GLO,
    ST_GHI,
    ST_GACC,
    ST_SCALE,
    ST_SQ,
    ST_ENERGY,
    ST_FRAME,
    ST_STOP
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FMUL_LO,
    OP_FMUL_HI,
    OP_GMUL_LO,
    OP_GMUL_HI,
    OP_ACC,
    OP_FILT,
    OP_SCALE,
    OP_SQ,
    OP_ENERGY,
    OP_FRAME,
    OP_STOP
  } dp_op_e;

  typedef struct packed {
    logic   arm;
    logic   load_x;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic recording;
    logic warm;
  } dp_status_t;

  typedef struct packed {
    logic [15:0]       filter_coeff;
    logic [15:0]       gain;
    logic [15:0]       warmup_samples;
    logic [FLEN_W-1:0] frame_len;
    logic [THR_W-1:0]  energy_threshold;
    logic [CNT_W-1:0]  grace_samples;
    logic [CNT_W-1:0]  hangover_samples;
    logic [CNT_W-1:0]  capacity_samples;
  } cfg_t;

endpackage

@@ rtl/mic_sample_conditioner_vad.sv @@
// Microphone sample conditioner: DC blocker, gain, int16 saturation, energy VAD.
// Top level with APB register bank; uses mscvad_pkg, mscvad_ctrl, mscvad_datapath.
// An accepted word steps through the multiply, filter, gain, scale, square, energy, frame and
// stop states before its result is registered on the output; a warm-up sample ends at scale.
// Beats are taken only in idle; the one shared 17x21 multiplier is used four times per sample.
// Reset (rst_ni, async): registers back to defaults, not recording, no output.
module mic_sample_conditioner_vad #(
  parameter int unsigned FRAME_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] raw_word
  input  logic [0:0]  s_axis_tuser,   // [0] command
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
  output logic [3:0]  m_axis_tuser,   // [0] clipped, [1] speech_seen, [3:2] stop_reason
  output logic        m_axis_tlast,   // stop
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mscvad_pkg::*;

  cfg_t         cfg_q;
  reg_idx_e     reg_idx;
  logic         reg_wr;
  dp_cmd_t      cmd;
  dp_status_t   status;
  stop_reason_e reason;
  logic         clipped, speech;

  // Register bank, one 64-bit slot per register
  assign reg_idx = reg_idx_e'(paddr[5:3]);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_coeff     <= RST_FILTER_COEFF;
      cfg_q.gain             <= RST_GAIN;
      cfg_q.warmup_samples   <= RST_WARMUP;
      cfg_q.frame_len        <= RST_FRAME_LEN;
      cfg_q.energy_threshold <= RST_THRESHOLD;
      cfg_q.grace_samples    <= RST_GRACE;
      cfg_q.hangover_samples <= RST_HANGOVER;
      cfg_q.capacity_samples <= RST_CAPACITY;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_FILTER_COEFF: cfg_q.filter_coeff     <= pwdata[15:0];
        REG_GAIN:         cfg_q.gain             <= pwdata[15:0];
        REG_WARMUP:       cfg_q.warmup_samples   <= pwdata[15:0];
        REG_FRAME_LEN:    cfg_q.frame_len        <= pwdata[FLEN_W-1:0];
        REG_THRESHOLD:    cfg_q.energy_threshold <= pwdata[THR_W-1:0];
        REG_GRACE:        cfg_q.grace_samples    <= pwdata[CNT_W-1:0];
        REG_HANGOVER:     cfg_q.hangover_samples <= pwdata[CNT_W-1:0];
        REG_CAPACITY:     cfg_q.capacity_samples <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      REG_FILTER_COEFF: prdata = APB_DW'(cfg_q.filter_coeff);
      REG_GAIN:         prdata = APB_DW'(cfg_q.gain);
      REG_WARMUP:       prdata = APB_DW'(cfg_q.warmup_samples);
      REG_FRAME_LEN:    prdata = APB_DW'(cfg_q.frame_len);
      REG_THRESHOLD:    prdata = APB_DW'(cfg_q.energy_threshold);
      REG_GRACE:        prdata = APB_DW'(cfg_q.grace_samples);
      REG_HANGOVER:     prdata = APB_DW'(cfg_q.hangover_samples);
      REG_CAPACITY:     prdata = APB_DW'(cfg_q.capacity_samples);
      default:          prdata = '0;
    endcase
  end

  mscvad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_command_i (s_axis_tuser[0]),
    .s_tready_o  (s_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mscvad_datapath #(
    .FRAME_MAX (FRAME_MAX)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .raw_hi_i  (s_axis_tdata[31:16]),
    .status_o  (status),
    .pcm_o     (m_axis_tdata),
    .clipped_o (clipped),
    .speech_o  (speech),
    .stop_o    (m_axis_tlast),
    .reason_o  (reason)
  );

  assign m_axis_tuser = {reason, speech, clipped};

endmodule

@@ rtl/mscvad_datapath.sv @@
// Datapath: DC blocker, gain, saturation, frame energy and stop detection.
// Depends on mscvad_pkg and the assertion macro header.
`include "mic_sample_conditioner_vad_macros.svh"

module mscvad_datapath #(
  parameter int unsigned FRAME_MAX = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mscvad_pkg::cfg_t            cfg_i,
  input  mscvad_pkg::dp_cmd_t         cmd_i,
  input  logic [15:0]                 raw_hi_i,
  output mscvad_pkg::dp_status_t      status_o,
  output logic [15:0]                 pcm_o,
  output logic                        clipped_o,
  output logic                        speech_o,
  output logic                        stop_o,
  output mscvad_pkg::stop_reason_e    reason_o
);
  import mscvad_pkg::*;

  localparam int unsigned FW = $clog2(FRAME_MAX + 1);
  localparam int unsigned CW = (FW > FLEN_W) ? FW : FLEN_W;

  // Recording state
  logic                     recording_q, recording_d;
  logic signed [RAW_W-1:0]  x_q, prev_raw_q;
  logic signed [FILT_W-1:0] prev_filt_q;
  logic signed [MUL_W-1:0]  mul_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PCM_W-1:0]  v_q;
  logic                     clip_q;
  logic [SQ_W-1:0]          sq_q;
  logic [15:0]              warmup_q;
  logic [ENER_W-1:0]        energy_q;
  logic [FW-1:0]            fcnt_q;
  logic                     frame_end_q;
  logic                     speech_q;
  logic [TIME_W-1:0]        elapsed_q, last_voice_q;
  logic [CNT_W-1:0]         stored_q;

  // Shared multiplier: 17-bit unsigned coefficient by a 21-bit signed slice
  logic                     mul_gain, mul_hi;
  logic signed [16:0]       mul_a;
  logic signed [20:0]       mul_b;
  logic signed [MUL_W-1:0]  mul_p;

  assign mul_gain = (cmd_i.op == OP_GMUL_LO) || (cmd_i.op == OP_GMUL_HI);
  assign mul_hi   = (cmd_i.op == OP_FMUL_HI) || (cmd_i.op == OP_GMUL_HI);
  assign mul_a    = signed'({1'b0, mul_gain ? cfg_i.gain : cfg_i.filter_coeff});
  assign mul_b    = mul_hi ? signed'({prev_filt_q[FILT_W-1], prev_filt_q[FILT_W-1:20]})
                           : signed'({1'b0, prev_filt_q[19:0]});
  assign mul_p    = mul_a * mul_b;

  // Partial product aligned for accumulation
  logic signed [ACC_W-1:0] mul_ext;
  assign mul_ext = {{(ACC_W-MUL_W){mul_q[MUL_W-1]}}, mul_q};

  // Filter output before saturation
  logic signed [RAW_W:0]    diff;
  logic signed [ACC_W-1:0]  y_full;
  logic                     y_ovf_hi, y_ovf_lo;
  logic signed [FILT_W-1:0] y_sat;

  assign diff     = {x_q[RAW_W-1], x_q} - {prev_raw_q[RAW_W-1], prev_raw_q};
  assign y_full   = (signed'({{(ACC_W-RAW_W-1){diff[RAW_W]}}, diff}) <<< 16) +
                    (acc_q >>> 16);
  assign y_ovf_hi = !y_full[ACC_W-1] && (|y_full[ACC_W-2:FILT_W-1]);
  assign y_ovf_lo = y_full[ACC_W-1] && !(&y_full[ACC_W-2:FILT_W-1]);
  assign y_sat    = y_ovf_hi ? {1'b0, {(FILT_W-1){1'b1}}} :
                    y_ovf_lo ? {1'b1, {(FILT_W-1){1'b0}}} : y_full[FILT_W-1:0];

  // Q.24 to integer, truncated toward zero, then clamped to int16
  logic signed [ACC_W-1:0] s_bias, q_full;
  logic                    q_ovf_hi, q_ovf_lo;
  logic signed [PCM_W-1:0] v_sat;

  assign s_bias   = acc_q + (acc_q[ACC_W-1] ? ACC_W'(24'hFF_FFFF) : '0);
  assign q_full   = s_bias >>> 24;
  assign q_ovf_hi = !q_full[ACC_W-1] && (|q_full[ACC_W-2:PCM_W-1]);
  assign q_ovf_lo = q_full[ACC_W-1] && !(&q_full[ACC_W-2:PCM_W-1]);
  assign v_sat    = q_ovf_hi ? {1'b0, {(PCM_W-1){1'b1}}} :
                    q_ovf_lo ? {1'b1, {(PCM_W-1){1'b0}}} : q_full[PCM_W-1:0];

  // Square of the sample; never negative
  logic signed [SQ_W-1:0] sq_p;
  assign sq_p = v_q * v_q;

  // Energy accumulation with saturation
  logic [ENER_W:0]   ener_sum;
  logic [ENER_W-1:0] ener_sat;
  assign ener_sum = {1'b0, energy_q} + {{(ENER_W+1-SQ_W){1'b0}}, sq_q};
  assign ener_sat = ener_sum[ENER_W] ? {ENER_W{1'b1}} : ener_sum[ENER_W-1:0];

  // Effective frame length: zero counts as one, capped at FRAME_MAX
  logic [CW-1:0] flen_ext, flen_cw;
  logic [FW-1:0] flen, fcnt_inc;
  assign flen_ext = CW'(cfg_i.frame_len);
  assign flen_cw  = (flen_ext == '0) ? CW'(1) :
                    (flen_ext > CW'(FRAME_MAX)) ? CW'(FRAME_MAX) : flen_ext;
  assign flen     = flen_cw[FW-1:0];
  assign fcnt_inc = fcnt_q + FW'(1);

  // Stop conditions
  logic              stop_full, stop_silence, stop_c;
  logic [TIME_W-1:0] quiet_time;
  stop_reason_e      reason_c;
  assign quiet_time   = elapsed_q - last_voice_q;
  assign stop_full    = stored_q >= cfg_i.capacity_samples;
  assign stop_silence = speech_q && (elapsed_q >= TIME_W'(cfg_i.grace_samples)) &&
                        (quiet_time >= TIME_W'(cfg_i.hangover_samples));
  assign stop_c       = stop_full || stop_silence;
  assign reason_c     = stop_full ? REASON_FULL :
                        stop_silence ? REASON_SILENCE : REASON_NONE;

  // Recording flag: set by start, cleared by a stop
  always_comb begin
    recording_d = recording_q;
    if (cmd_i.arm) begin
      recording_d = 1'b1;
    end else if (cmd_i.op == OP_STOP && stop_c) begin
      recording_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recording_q <= 1'b0;
    end else begin
      recording_q <= recording_d;
    end
  end

  // Per-recording state and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.arm) begin
      prev_raw_q   <= '0;
      prev_filt_q  <= '0;
      warmup_q     <= cfg_i.warmup_samples;
      energy_q     <= '0;
      fcnt_q       <= '0;
      speech_q     <= 1'b0;
      elapsed_q    <= '0;
      last_voice_q <= '0;
      stored_q     <= '0;
    end else begin
      if (cmd_i.load_x) begin
        x_q <= raw_hi_i;
      end
      case (cmd_i.op)
        OP_FMUL_LO, OP_GMUL_LO: begin
          mul_q <= mul_p;
        end
        OP_FMUL_HI, OP_GMUL_HI: begin
          acc_q <= mul_ext;
          mul_q <= mul_p;
        end
        OP_ACC: begin
          acc_q <= acc_q + (mul_ext <<< 20);
        end
        OP_FILT: begin
          prev_raw_q  <= x_q;
          prev_filt_q <= y_sat;
        end
        OP_SCALE: begin
          v_q       <= v_sat;
          clip_q    <= q_ovf_hi || q_ovf_lo;
          elapsed_q <= elapsed_q + TIME_W'(1);
          if (warmup_q != '0) begin
            warmup_q <= warmup_q - 16'd1;
          end
        end
        OP_SQ: begin
          sq_q <= unsigned'(sq_p);
        end
        OP_ENERGY: begin
          energy_q    <= ener_sat;
          fcnt_q      <= fcnt_inc;
          frame_end_q <= fcnt_inc >= flen;
          stored_q    <= stored_q + CNT_W'(1);
        end
        OP_FRAME: begin
          if (frame_end_q) begin
            if (energy_q >= {1'b0, cfg_i.energy_threshold}) begin
              speech_q     <= 1'b1;
              last_voice_q <= elapsed_q;
            end
            energy_q <= '0;
            fcnt_q   <= '0;
          end
        end
        OP_STOP: begin
          pcm_o     <= v_q;
          clipped_o <= clip_q;
          speech_o  <= speech_q;
          stop_o    <= stop_c;
          reason_o  <= reason_c;
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o.recording = recording_q;
  assign status_o.warm      = warmup_q != '0;

  `MSCV_ASSERT_NEXT(a_stop_ends_rec, cmd_i.op == OP_STOP && stop_c && !cmd_i.arm, !recording_q, "stop did not end recording")
  `MSCV_ASSERT_NEXT(a_arm_clears, cmd_i.arm, recording_q && stored_q == '0 && elapsed_q == '0, "start did not re-arm")
  `MSCV_ASSERT_NEXT(a_reason_match, cmd_i.op == OP_STOP && !cmd_i.arm, stop_o == (reason_o != REASON_NONE), "stop flag and reason disagree")

endmodule

@@ rtl/mscvad_ctrl.sv @@
// Sequencer for the conditioner: handshakes and datapath step commands.
// Depends on mscvad_pkg and the assertion macro header.
`include "mic_sample_conditioner_vad_macros.svh"

module mscvad_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_command_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  input  mscvad_pkg::dp_status_t status_i,
  output mscvad_pkg::dp_cmd_t    cmd_o
);
  import mscvad_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   s_fire, out_free, out_load;

  assign s_fire   = s_tvalid_i && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_tready_i;
  assign out_load = (state_q == ST_STOP) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && command_e'(s_command_i) == CMD_WORD && status_i.recording) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_FACC;
      ST_FACC:   state_d = ST_FILT;
      ST_FILT:   state_d = ST_GLO;
      ST_GLO:    state_d = ST_GHI;
      ST_GHI:    state_d = ST_GACC;
      ST_GACC:   state_d = ST_SCALE;
      ST_SCALE:  state_d = status_i.warm ? ST_IDLE : ST_SQ;
      ST_SQ:     state_d = ST_ENERGY;
      ST_ENERGY: state_d = ST_FRAME;
      ST_FRAME:  state_d = ST_STOP;
      ST_STOP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o.arm    = s_fire && command_e'(s_command_i) == CMD_START;
    cmd_o.load_x = s_fire && command_e'(s_command_i) == CMD_WORD;
    unique case (state_q)
      ST_MUL_LO: cmd_o.op = OP_FMUL_LO;
      ST_MUL_HI: cmd_o.op = OP_FMUL_HI;
      ST_FACC:   cmd_o.op = OP_ACC;
      ST_FILT:   cmd_o.op = OP_FILT;
      ST_GLO:    cmd_o.op = OP_GMUL_LO;
      ST_GHI:    cmd_o.op = OP_GMUL_HI;
      ST_GACC:   cmd_o.op = OP_ACC;
      ST_SCALE:  cmd_o.op = OP_SCALE;
      ST_SQ:     cmd_o.op = OP_SQ;
      ST_ENERGY: cmd_o.op = OP_ENERGY;
      ST_FRAME:  cmd_o.op = OP_FRAME;
      ST_STOP:   cmd_o.op = out_free ? OP_STOP : OP_NONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  // Output beat holds until taken
  assign m_valid_d = (m_valid_q && !m_tready_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = m_valid_q;

  `MSCV_ASSERT_NEXT(a_load_shows, out_load, m_valid_q, "result not presented after load")
  `MSCV_ASSERT_NEXT(a_warm_no_result, state_q == ST_SCALE && status_i.warm, state_q == ST_IDLE, "warm-up sample went on")
  `MSCV_ASSERT_NEXT(a_word_starts, cmd_o.load_x && status_i.recording, state_q == ST_MUL_LO, "accepted word not processed")

endmodule

@@ dv/mic_sample_conditioner_vad_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mic_sample_conditioner_vad: stream in, stream out, APB registers.
// Every output beat is checked against an in-bench fixed-point predictor; uses mscvad_pkg.
module mic_sample_conditioner_vad_tb;
  import mscvad_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int unsigned FRAME_LIMIT   = 4096;
  localparam int unsigned RST_CYCLES    = 12;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned RANDOM_BEATS  = 600;
  localparam longint      Y_MAX         = (64'sd1 <<< 39) - 1;
  localparam longint      Y_MIN         = -(64'sd1 <<< 39);
  localparam longint      E_MAX         = (64'sd1 <<< 43) - 1;
  localparam longint      PCM_MAX       = 32767;
  localparam longint      PCM_MIN       = -32768;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;    // [31:0] raw_word
  logic [0:0]  s_axis_tuser  = '0;    // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [15:0] pcm_sample
  logic [3:0]  m_axis_tuser;          // [0] clipped, [1] speech_seen, [3:2] stop_reason
  logic        m_axis_tlast;          // stop
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [5:0]  paddr         = '0;
  logic [63:0] pwdata        = '0;
  logic [63:0] prdata;
  logic        pready;

  typedef struct {
    logic [15:0]  pcm;
    logic         clipped;
    logic         speech;
    logic         stop;
    stop_reason_e reason;
  } pcm_beat_t;

  pcm_beat_t pcm_expect_q[$];
  pcm_beat_t due_res;

  // Bench control
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_count = 0;
  int unsigned n_errors = 0;
  int unsigned beats_fed = 0;

  // Predictor: register copy and recording state
  cfg_t               cfg_shadow;
  bit                 rec_on      = 1'b0;
  bit                 speech_on   = 1'b0;
  logic signed [15:0] last_x      = '0;
  logic signed [39:0] dc_state    = '0;
  logic [15:0]        warm_left   = '0;
  logic [42:0]        frame_sum   = '0;
  logic [12:0]        frame_pos   = '0;
  logic [31:0]        sample_time = '0;
  logic [31:0]        voice_time  = '0;
  logic [23:0]        stored_n    = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mic_sample_conditioner_vad #(
    .FRAME_MAX(FRAME_LIMIT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  function automatic void check_field(string what, logic [63:0] expv, logic [63:0] got);
    if (got !== expv) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expv, got);
    end
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [63:0] val);
    case (idx)
      REG_FILTER_COEFF: cfg_shadow.filter_coeff     = val[15:0];
      REG_GAIN:         cfg_shadow.gain             = val[15:0];
      REG_WARMUP:       cfg_shadow.warmup_samples   = val[15:0];
      REG_FRAME_LEN:    cfg_shadow.frame_len        = val[FLEN_W-1:0];
      REG_THRESHOLD:    cfg_shadow.energy_threshold = val[THR_W-1:0];
      REG_GRACE:        cfg_shadow.grace_samples    = val[CNT_W-1:0];
      REG_HANGOVER:     cfg_shadow.hangover_samples = val[CNT_W-1:0];
      default:          cfg_shadow.capacity_samples = val[CNT_W-1:0];
    endcase
  endfunction

  function automatic logic [63:0] reg_value(reg_idx_e idx);
    case (idx)
      REG_FILTER_COEFF: return 64'(cfg_shadow.filter_coeff);
      REG_GAIN:         return 64'(cfg_shadow.gain);
      REG_WARMUP:       return 64'(cfg_shadow.warmup_samples);
      REG_FRAME_LEN:    return 64'(cfg_shadow.frame_len);
      REG_THRESHOLD:    return 64'(cfg_shadow.energy_threshold);
      REG_GRACE:        return 64'(cfg_shadow.grace_samples);
      REG_HANGOVER:     return 64'(cfg_shadow.hangover_samples);
      default:          return 64'(cfg_shadow.capacity_samples);
    endcase
  endfunction

  function automatic void arm_recording();
    rec_on      = 1'b1;
    last_x      = '0;
    dc_state    = '0;
    warm_left   = cfg_shadow.warmup_samples;
    frame_sum   = '0;
    frame_pos   = '0;
    speech_on   = 1'b0;
    sample_time = '0;
    voice_time  = '0;
    stored_n    = '0;
  endfunction

  // Advance the predictor by one accepted input beat; queue the output beat it causes
  function automatic void condition_beat(command_e cmd, logic [31:0] word);
    longint      x, prod, y, s, v, esum;
    int unsigned flen;
    logic [31:0] quiet_for;
    pcm_beat_t   res;
    if (cmd == CMD_START) begin
      arm_recording();
      return;
    end
    if (!rec_on) return;

    // DC blocker: pole times previous output, floored, then clamped to 40 bits
    x    = longint'($signed(word[31:16]));
    prod = (longint'(cfg_shadow.filter_coeff) * longint'(dc_state)) >>> 16;
    y    = (x - longint'(last_x)) * 65536 + prod;
    if (y > Y_MAX) y = Y_MAX;
    else if (y < Y_MIN) y = Y_MIN;
    last_x   = x[15:0];
    dc_state = y[39:0];

    // Q8.8 gain, drop 24 fractional bits toward zero, saturate to int16
    s = y * longint'(cfg_shadow.gain);
    v = s / 64'sd16777216;
    res.clipped = (v > PCM_MAX) || (v < PCM_MIN);
    if (v > PCM_MAX) v = PCM_MAX;
    else if (v < PCM_MIN) v = PCM_MIN;

    sample_time++;
    if (warm_left != 0) begin
      warm_left--;
      return;
    end
    stored_n++;

    // Frame energy, saturating
    esum = longint'(frame_sum) + v * v;
    if (esum > E_MAX) esum = E_MAX;
    frame_sum = esum[42:0];
    frame_pos++;
    flen = (cfg_shadow.frame_len == 0) ? 1 : cfg_shadow.frame_len;
    if (flen > FRAME_LIMIT) flen = FRAME_LIMIT;
    if (frame_pos >= flen) begin
      if (frame_sum >= cfg_shadow.energy_threshold) begin
        speech_on  = 1'b1;
        voice_time = sample_time;
      end
      frame_sum = '0;
      frame_pos = '0;
    end

    // Auto-stop: buffer full wins over silence hangover
    quiet_for  = sample_time - voice_time;
    res.reason = REASON_NONE;
    if (stored_n >= cfg_shadow.capacity_samples) begin
      res.reason = REASON_FULL;
    end else if (speech_on && sample_time >= 32'(cfg_shadow.grace_samples) &&
                 quiet_for >= 32'(cfg_shadow.hangover_samples)) begin
      res.reason = REASON_SILENCE;
    end
    res.stop = (res.reason != REASON_NONE);
    if (res.stop) rec_on = 1'b0;
    res.pcm    = v[15:0];
    res.speech = speech_on;
    pcm_expect_q.push_back(res);
  endfunction

  function automatic logic [31:0] quiet_word();
    int lvl;
    lvl = int'($urandom_range(16)) - 8;
    return {lvl[15:0], 16'($urandom)};
  endfunction

  // Receiver: random stalls, or a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Output checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pcm_expect_q.size() == 0) begin
        n_errors++;
        $display("%0t: output beat with nothing expected, expected none, got pcm %0h",
                 $time, m_axis_tdata);
      end else begin
        due_res = pcm_expect_q.pop_front();
        check_field("pcm_sample", due_res.pcm, m_axis_tdata);
        check_field("clipped", due_res.clipped, m_axis_tuser[0]);
        check_field("speech_seen", due_res.speech, m_axis_tuser[1]);
        check_field("stop", due_res.stop, m_axis_tlast);
        check_field("stop_reason", due_res.reason, m_axis_tuser[3:2]);
      end
    end
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_count = 0;
    end else if (++stall_count >= STALL_LIMIT) begin
      $display("mic_sample_conditioner_vad test failed");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_e idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_back_all();
    reg_idx_e idx;
    idx = idx.first();
    do begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      check_field($sformatf("register %s", idx.name()), reg_value(idx), prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
  endtask

  // Drop the input, wait for every queued result, then let in-flight work finish
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pcm_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_cfg(input logic [15:0] coeff, input logic [15:0] gain,
                         input logic [15:0] warm, input logic [12:0] flen,
                         input logic [41:0] thr, input logic [23:0] grace,
                         input logic [23:0] hang, input logic [23:0] cap);
    wait_quiet();
    apb_write(REG_FILTER_COEFF, 64'(coeff));
    apb_write(REG_GAIN, 64'(gain));
    apb_write(REG_WARMUP, 64'(warm));
    apb_write(REG_FRAME_LEN, 64'(flen));
    apb_write(REG_THRESHOLD, 64'(thr));
    apb_write(REG_GRACE, 64'(grace));
    apb_write(REG_HANGOVER, 64'(hang));
    apb_write(REG_CAPACITY, 64'(cap));
  endtask

  // One input beat; valid stays up across back-to-back beats
  task automatic send_beat(input command_e cmd, input logic [31:0] word);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_START || rec_on) beats_fed++;
    condition_beat(cmd, word);
  endtask

  // Reset values, then every register at its top (frame length at FRAME_LIMIT) and at zero
  task automatic test_registers();
    reg_idx_e idx;
    read_back_all();
    idx = idx.first();
    do begin
      case (idx)
        REG_FRAME_LEN:                         apb_write(idx, 64'(FRAME_LIMIT));
        REG_THRESHOLD:                         apb_write(idx, 64'h3FF_FFFF_FFFF);
        REG_GRACE, REG_HANGOVER, REG_CAPACITY: apb_write(idx, 64'hFF_FFFF);
        default:                               apb_write(idx, 64'hFFFF);
      endcase
      idx = idx.next();
    end while (idx != idx.first());
    read_back_all();
    idx = idx.first();
    do begin
      apb_write(idx, 64'h0);
      idx = idx.next();
    end while (idx != idx.first());
    read_back_all();
  endtask

  task automatic test_directed();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    // Full-scale gain clips; zero frame length makes each sample a frame
    set_cfg(RST_FILTER_COEFF, 16'hFFFF, 16'd2, 13'd0, 42'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_beat(CMD_WORD, 32'h7FFF_0000);      // word while idle
    send_beat(CMD_START, 32'hFFFF_FFFF);     // payload on start is ignored
    send_beat(CMD_WORD, 32'h7FFF_FFFF);      // warm-up
    send_beat(CMD_WORD, 32'h8000_0000);      // warm-up
    send_beat(CMD_WORD, 32'h7FFF_0000);
    send_beat(CMD_WORD, 32'h8000_0000);
    send_beat(CMD_WORD, 32'h0000_0000);
    send_beat(CMD_WORD, 32'hFFFF_FFFF);
    send_beat(CMD_WORD, 32'h0000_FFFF);
    send_beat(CMD_START, 32'h1234_5678);     // restart mid-recording
    send_beat(CMD_WORD, 32'h8000_0000);
    send_beat(CMD_WORD, 32'h8000_0000);
    send_beat(CMD_WORD, 32'h7FFF_0000);
    // Zero capacity stops on the first sample; oversized frame length; no gain
    set_cfg(16'h0000, 16'h0000, 16'd0, 13'h1FFF, 42'h3FF_FFFF_FFFF, 24'd0, 24'd0, 24'd0);
    send_beat(CMD_START, 32'h0);
    send_beat(CMD_WORD, 32'h4000_0000);
    send_beat(CMD_WORD, 32'h4000_0000);      // after the stop: ignored
    // Speech then silence; with no pole a flat input filters to zero at once
    set_cfg(16'h0000, RST_GAIN, 16'd0, 13'd1, 42'd1000000, 24'd0, 24'd2, 24'hFF_FFFF);
    send_beat(CMD_START, 32'h0);
    send_beat(CMD_WORD, 32'h4000_0000);
    send_beat(CMD_WORD, 32'hC000_0000);
    repeat (4) send_beat(CMD_WORD, 32'h0000_0000);
  endtask

  // Output held off while the input keeps offering, then a full drain pause
  task automatic test_backpressure();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    set_cfg(RST_FILTER_COEFF, RST_GAIN, 16'd0, 13'd8, 42'd20000000, 24'd0, 24'hFF_FFFF,
            24'hFF_FFFF);
    send_beat(CMD_START, $urandom);
    hold_req = HOLD_CYCLES;
    repeat (48) send_beat(CMD_WORD, $urandom);
    wait_quiet();
    repeat (16) send_beat(CMD_WORD, quiet_word());
  endtask

  // Random recordings under one idling mix: random setting, start, shaped words
  task automatic test_random_phase(input int unsigned idle_snd, input int unsigned idle_rcv);
    int unsigned goal, n_words, style, burst;
    logic [15:0] coeff, gain, warm;
    logic [12:0] flen;
    logic [41:0] thr;
    logic [23:0] grace, hang, cap;
    logic [31:0] word;
    snd_idle_pct  = idle_snd;
    rcv_stall_pct = idle_rcv;
    goal = beats_fed + RANDOM_BEATS;
    while (beats_fed < goal) begin
      case ($urandom_range(9))
        0:       coeff = 16'h0000;
        1:       coeff = 16'hFFFF;
        2, 3, 4: coeff = RST_FILTER_COEFF;
        default: coeff = 16'($urandom);
      endcase
      case ($urandom_range(9))
        0:          gain = 16'h0000;
        1:          gain = 16'hFFFF;
        2, 3, 4, 5: gain = RST_GAIN;
        default:    gain = 16'($urandom_range(2048));
      endcase
      warm = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(6));
      case ($urandom_range(19))
        0:       flen = 13'd0;
        1:       flen = 13'h1FFF;
        2:       flen = 13'(FRAME_LIMIT);
        3:       flen = 13'd1;
        default: flen = 13'($urandom_range(2, 12));
      endcase
      case ($urandom_range(19))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = 42'($urandom_range(1000, 20000000));
      endcase
      grace = ($urandom_range(19) == 0) ? '1 : 24'($urandom_range(60));
      hang  = ($urandom_range(19) == 0) ? '1 : 24'($urandom_range(40));
      case ($urandom_range(19))
        0:       cap = '0;
        1:       cap = '1;
        default: cap = 24'($urandom_range(1, 80));
      endcase
      set_cfg(coeff, gain, warm, flen, thr, grace, hang, cap);

      send_beat(CMD_START, $urandom);
      n_words = $urandom_range(10, 100);
      style   = $urandom_range(3);
      burst   = $urandom_range(1, 30);
      for (int unsigned i = 0; i < n_words && rec_on; i++) begin
        if ($urandom_range(99) == 0) send_beat(CMD_START, $urandom);
        case (style)
          0:       word = $urandom;
          1:       word = (i < burst) ? $urandom : quiet_word();
          2:       word = quiet_word();
          default: word = $urandom_range(1) ? $urandom : quiet_word();
        endcase
        send_beat(CMD_WORD, word);
      end
      // stray words once the recording has ended
      repeat ($urandom_range(2)) send_beat(CMD_WORD, $urandom);
    end
  endtask

  initial begin
    cfg_shadow.filter_coeff     = RST_FILTER_COEFF;
    cfg_shadow.gain             = RST_GAIN;
    cfg_shadow.warmup_samples   = RST_WARMUP;
    cfg_shadow.frame_len        = RST_FRAME_LEN;
    cfg_shadow.energy_threshold = RST_THRESHOLD;
    cfg_shadow.grace_samples    = RST_GRACE;
    cfg_shadow.hangover_samples = RST_HANGOVER;
    cfg_shadow.capacity_samples = RST_CAPACITY;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_registers();
    test_directed();
    test_backpressure();
    test_random_phase(26, 61);
    test_random_phase(61, 26);
    test_random_phase(0, 0);

    wait_quiet();
    if (n_errors == 0 && pcm_expect_q.size() == 0) begin
      $display("mic_sample_conditioner_vad test passed");
    end else begin
      $display("mic_sample_conditioner_vad test failed");
    end
    $finish;
  end

endmodule
